### src/crccfg_pkg.sv
// ----------------------------------------------------------------------------
// crccfg_pkg: shared types and constants of the configurable-width CRC engine
// Holds the payload structs of both channels, the register map of the
// configuration port, reset values and the width limits.
// ----------------------------------------------------------------------------
`default_nettype none

package crccfg_pkg;

	localparam int CRC_MAX_WIDTH_DEF = 16;   // default of the MaxWidth parameter
	localparam int CRC_MIN_WIDTH     = 8;
	localparam int BYTE_W            = 8;
	localparam int CRC_FIELD_W       = 16;   // width of seed and crc fields
	localparam int CFG_DATA_W        = 16;   // widest register: polynomial
	localparam int CFG_IDX_W         = 1;
	localparam int CFG_WIDTH_FIELD_W = 5;    // bits of a crc_width write

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CRC_WIDTH  = 1'b0,
		REG_POLYNOMIAL = 1'b1
	} cfg_reg_t;

	localparam logic [CFG_WIDTH_FIELD_W-1:0] CRC_WIDTH_RESET  = 5'd8;
	localparam logic [CFG_DATA_W-1:0]        POLYNOMIAL_RESET = 16'h0007;

	typedef struct packed {
		logic [BYTE_W-1:0]      data_byte;
		logic                   first_byte;
		logic [CRC_FIELD_W-1:0] seed_value;
		logic                   last_byte;
	} byte_item_t;

	typedef struct packed {
		logic [CRC_FIELD_W-1:0] crc_value;
		logic                   message_done;
	} crc_item_t;

endpackage

`default_nettype wire

### src/crccfg_byte_upd.sv
// ----------------------------------------------------------------------------
// crccfg_byte_upd: one-byte MSB-first CRC update
// Left-aligns the remainder and polynomial to MaxWidth bits so that any width
// runs through the same eight shift-and-reduce steps, then aligns back.
// ----------------------------------------------------------------------------
`default_nettype none

module crccfg_byte_upd #(
	parameter int MaxWidth = crccfg_pkg::CRC_MAX_WIDTH_DEF
) (
	input  wire logic [$clog2(MaxWidth+1)-1:0] crc_width,
	input  wire logic [MaxWidth-1:0]           polynomial,
	input  wire logic [MaxWidth-1:0]           start,
	input  wire logic [crccfg_pkg::BYTE_W-1:0] data_byte,
	output logic      [MaxWidth-1:0]           result
);
	import crccfg_pkg::*;

	localparam int WW = $clog2(MaxWidth + 1);

	logic [WW-1:0]       align_sh;
	logic [MaxWidth-1:0] rem_al;
	logic [MaxWidth-1:0] poly_al;

	always_comb begin
		align_sh = WW'(MaxWidth) - crc_width;
		// bits at or above the width fall off the top here
		rem_al  = start << align_sh;
		poly_al = polynomial << align_sh;
		rem_al[MaxWidth-1 -: BYTE_W] = rem_al[MaxWidth-1 -: BYTE_W] ^ data_byte;
		for (int k = 0; k < BYTE_W; k++) begin
			if (rem_al[MaxWidth-1]) begin
				rem_al = (rem_al << 1) ^ poly_al;
			end else begin
				rem_al = rem_al << 1;
			end
		end
		result = rem_al >> align_sh;
	end

endmodule

`default_nettype wire

### src/crc_configurable_width_byte_update.sv
// ----------------------------------------------------------------------------
// crc_configurable_width_byte_update: MSB-first CRC, width 8..MaxWidth
// Absorbs one message byte per transfer into a running remainder with a
// programmable polynomial and returns the running CRC for every byte.
// ----------------------------------------------------------------------------
//
//   channel   signals                           dir   transfer when
//   --------  --------------------------------  ----  -------------------------
//   byte      byte_valid, byte_stall, byte_data  in    valid high, stall low
//   crc       crc_valid, crc_stall, crc_data     out   valid high, stall low
//   cfg       cfg_we, cfg_index, cfg_wdata       in    cfg_we high
//
// One byte per cycle while the crc side does not stall. A byte goes to the
// input register on its transfer and its CRC is loaded into the result
// register once that register is empty or being drained, with the eight-step
// XOR update between the input and result registers.
// Reset gives width 8, polynomial 0x07 and a remainder of zero.
// A stall on the crc side holds the result register; the input register
// keeps taking bytes until it holds one that cannot move on.
// ----------------------------------------------------------------------------
`default_nettype none

module crc_configurable_width_byte_update #(
	parameter int MaxWidth = crccfg_pkg::CRC_MAX_WIDTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// byte channel
	input  wire logic                             byte_valid,
	output logic                                  byte_stall,
	input  wire crccfg_pkg::byte_item_t           byte_data,
	// crc channel
	output logic                                  crc_valid,
	input  wire logic                             crc_stall,
	output crccfg_pkg::crc_item_t                 crc_data,
	// configuration
	input  wire logic                             cfg_we,
	input  wire logic [crccfg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [crccfg_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import crccfg_pkg::*;

	localparam int WW = $clog2(MaxWidth + 1);

	// configuration registers
	logic [WW-1:0]       crc_width_q;
	logic [MaxWidth-1:0] polynomial_q;

	// running remainder, right-aligned
	logic [MaxWidth-1:0] remainder_q;

	// input stage
	logic       valid_s1;
	byte_item_t item_s1;

	// result stage
	logic      out_valid_q;
	crc_item_t out_item_q;

	logic                         out_load;
	logic [CFG_WIDTH_FIELD_W-1:0] width_wr;
	logic [CFG_WIDTH_FIELD_W-1:0] width_sat;
	logic [MaxWidth-1:0]          start;
	logic [MaxWidth-1:0]          next_rem;

	// ---- configuration writes: saturate the width into 8..MaxWidth ----
	always_comb begin
		width_wr = cfg_wdata[CFG_WIDTH_FIELD_W-1:0];
		if (width_wr < CFG_WIDTH_FIELD_W'(CRC_MIN_WIDTH)) begin
			width_sat = CFG_WIDTH_FIELD_W'(CRC_MIN_WIDTH);
		end else if (width_wr > CFG_WIDTH_FIELD_W'(MaxWidth)) begin
			width_sat = CFG_WIDTH_FIELD_W'(MaxWidth);
		end else begin
			width_sat = width_wr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_width_q  <= CRC_WIDTH_RESET[WW-1:0];
			polynomial_q <= POLYNOMIAL_RESET[MaxWidth-1:0];
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_CRC_WIDTH:  crc_width_q  <= width_sat[WW-1:0];
				REG_POLYNOMIAL: polynomial_q <= cfg_wdata[MaxWidth-1:0];
				default: ;
			endcase
		end
	end

	// ---- flow control ----
	// load the result register whenever it is empty or being drained
	assign out_load   = !out_valid_q || !crc_stall;
	// hold off the byte side only while the input register cannot move on
	assign byte_stall = valid_s1 && !out_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			item_s1 <= byte_data;
		end
	end

	// ---- byte update ----
	// a first byte restarts from the seed; bits above the width drop in the update
	assign start = item_s1.first_byte ? item_s1.seed_value[MaxWidth-1:0] : remainder_q;

	crccfg_byte_upd #(
		.MaxWidth (MaxWidth)
	) u_byte_upd (
		.crc_width  (crc_width_q),
		.polynomial (polynomial_q),
		.start      (start),
		.data_byte  (item_s1.data_byte),
		.result     (next_rem)
	);

	// advance the remainder only when the byte moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remainder_q <= '0;
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				remainder_q <= next_rem;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load && valid_s1) begin
			out_item_q.crc_value    <= CRC_FIELD_W'(next_rem);
			out_item_q.message_done <= item_s1.last_byte;
		end
	end

	assign crc_valid = out_valid_q;
	assign crc_data  = out_item_q;

	// ---- assertions ----
	a_width_range: assert property (@(posedge clk) disable iff (!arst_n)
		(crc_width_q >= WW'(CRC_MIN_WIDTH)) && (crc_width_q <= WW'(MaxWidth)))
		else $error("crc width register left its legal range");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && crc_stall) |-> byte_stall)
		else $error("byte accepted while both stages are held");

	a_result_load: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !(out_valid_q && crc_stall)) |=> crc_valid)
		else $error("byte in input register did not reach the result register");

	a_rem_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!valid_s1) |=> $stable(remainder_q))
		else $error("remainder changed without a byte");

endmodule

`default_nettype wire
